@@ hdl/dsr_pkg.sv @@
package dsr_pkg;

   localparam int MAX_REQUESTS     = 16;
   localparam int TRACK_BITS       = 10;
   localparam int IDX_BITS         = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_BITS         = $clog2(MAX_REQUESTS + 1);
   localparam int KEY_BITS         = TRACK_BITS + 1;
   localparam int SUM_BITS         = 14;
   localparam int SUM_MAX          = 16383;
   localparam int COUNT_FIELD_BITS = 5;
   localparam int START_RESET      = 90;

   localparam int CSR_ADDR_BITS    = 1;
   localparam int CSR_DATA_BITS    = TRACK_BITS;
   localparam int REQ_DATA_BITS    = 16;
   localparam int REQ_PAD_BITS     = REQ_DATA_BITS - TRACK_BITS;
   localparam int RSP_FIELD_BITS   = 2 * TRACK_BITS + SUM_BITS + COUNT_FIELD_BITS;
   localparam int RSP_DATA_BITS    = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS     = RSP_DATA_BITS - RSP_FIELD_BITS;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_MODE  = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_START = 1'b1;

   localparam logic [1:0] MODE_FCFS = 2'd0;
   localparam logic [1:0] MODE_SSTF = 2'd1;
   localparam logic [1:0] MODE_SCAN = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_SEARCH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  live;
      logic                  found;
      logic [KEY_BITS-1:0]   key;
      logic [IDX_BITS-1:0]   idx;
      logic [TRACK_BITS-1:0] track;
   } token_type;

   typedef struct packed {
      logic                  wr_en;
      logic [IDX_BITS-1:0]   wr_idx;
      logic [TRACK_BITS-1:0] wr_track;
      logic                  mark_en;
      logic [IDX_BITS-1:0]   mark_idx;
      logic                  clear;
      logic [CNT_BITS-1:0]   count;
      logic [1:0]            mode;
      logic [TRACK_BITS-1:0] head;
      logic [TRACK_BITS-1:0] start;
   } cell_ctl_type;

   function automatic logic [TRACK_BITS-1:0] abs_diff(input logic [TRACK_BITS-1:0] a,
                                                       input logic [TRACK_BITS-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

@@ hdl/dsr_cell.sv @@
module dsr_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  dsr_pkg::cell_ctl_type         ctl,
   input  logic [dsr_pkg::IDX_BITS-1:0]  cell_index,
   input  dsr_pkg::token_type            prev_tok,
   output dsr_pkg::token_type            next_tok
);
   import dsr_pkg::*;

   logic [TRACK_BITS-1:0] track_ff;
   logic                  served_ff;
   logic                  served_in;
   token_type             tok_ff;
   token_type             tok_in;
   logic [KEY_BITS-1:0]   key;
   logic                  eligible;

   always_comb begin
      case (ctl.mode)
         MODE_SSTF: key = {1'b0, abs_diff(ctl.head, track_ff)};
         MODE_SCAN: key = (track_ff > ctl.start) ? {1'b0, track_ff} : {1'b1, ~track_ff};
         default:   key = '0;
      endcase
   end

   // A request is a candidate when it is loaded and not yet served. Strict
   // comparison lets the earliest loaded request win a tie.
   assign eligible = (CNT_BITS'(cell_index) < ctl.count) && !served_ff;

   always_comb begin
      tok_in = prev_tok;
      if (eligible && (!prev_tok.found || key < prev_tok.key)) begin
         tok_in.found = 1'b1;
         tok_in.key   = key;
         tok_in.idx   = cell_index;
         tok_in.track = track_ff;
      end
   end

   always_comb begin
      served_in = served_ff;
      if (ctl.clear) begin
         served_in = 1'b0;
      end else if (ctl.mark_en && ctl.mark_idx == cell_index) begin
         served_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en && ctl.wr_idx == cell_index) begin
         track_ff <= ctl.wr_track;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff.found <= tok_in.found;
      tok_ff.key   <= tok_in.key;
      tok_ff.idx   <= tok_in.idx;
      tok_ff.track <= tok_in.track;
      if (reset) begin
         served_ff   <= 1'b0;
         tok_ff.live <= 1'b0;
      end else begin
         served_ff   <= served_in;
         tok_ff.live <= tok_in.live;
      end
   end

   assign next_tok = tok_ff;

endmodule

@@ hdl/disk_request_scheduler.sv @@
// Disk request scheduler.
// Requests arrive on the req_ channel, one track per transaction; the
// transaction with req_tlast high closes the batch. Up to MAX_REQUESTS
// requests are kept, later ones are dropped and reported through the
// overflow flag in rsp_tuser. The block then returns one rsp_ transaction
// per stored request in service order, with rsp_tlast on the final one.
// The csr_ port selects the policy (first come, shortest seek, or an
// upward-then-downward sweep) and the starting head track; write it only
// while no batch is being loaded or served.
// Loading takes one cycle per request. Each result is found by a search
// token that walks the row of request cells, one cell per cycle; the
// first search starts once the batch closes, and the result is registered
// when the token leaves the last cell. req_tready stays low while a batch
// is served and returns the cycle after the final result is taken.
// A stalled receiver simply holds the current result; the next search
// starts when it is taken. Reset returns the block to loading with an
// empty batch, first come first served and start track 90.
module disk_request_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   // request_track in [9:0], zero fill above
   input  logic [dsr_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                               req_tlast,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // served_track, seek_distance, total_distance, request_count, zero fill
   output logic [dsr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // overflow
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [dsr_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [dsr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import dsr_pkg::*;

   state_type             state_ff, state_in;
   logic [1:0]            mode_ff;
   logic [TRACK_BITS-1:0] start_ff;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   logic [TRACK_BITS-1:0] head_ff, head_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [CNT_BITS-1:0]   served_cnt_ff, served_cnt_in;
   logic [TRACK_BITS-1:0] rsp_track_ff, rsp_track_in;
   logic [TRACK_BITS-1:0] rsp_seek_ff, rsp_seek_in;
   logic [SUM_BITS-1:0]   rsp_total_ff, rsp_total_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctl_type          ctl;
   logic                  start_search;
   token_type             launch_tok;
   token_type             chain [MAX_REQUESTS+1];
   token_type             best;
   logic [TRACK_BITS-1:0] seek;
   logic [SUM_BITS:0]     sum_wide;
   logic [SUM_BITS-1:0]   sum_next;

   always_comb begin
      launch_tok      = '0;
      launch_tok.live = start_search;
   end

   assign chain[0] = launch_tok;

   for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
      dsr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .cell_index (IDX_BITS'(i)),
         .prev_tok   (chain[i]),
         .next_tok   (chain[i+1])
      );
   end

   assign best     = chain[MAX_REQUESTS];
   assign seek     = abs_diff(head_ff, best.track);
   assign sum_wide = (SUM_BITS+1)'(sum_ff) + (SUM_BITS+1)'(seek);
   assign sum_next = (sum_wide > (SUM_BITS+1)'(SUM_MAX)) ? SUM_BITS'(SUM_MAX)
                                                         : sum_wide[SUM_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      head_in       = head_ff;
      sum_in        = sum_ff;
      served_cnt_in = served_cnt_ff;
      rsp_track_in  = rsp_track_ff;
      rsp_seek_in   = rsp_seek_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_last_in   = rsp_last_ff;
      start_search  = 1'b0;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;

      ctl.wr_en     = 1'b0;
      ctl.wr_idx    = count_ff[IDX_BITS-1:0];
      ctl.wr_track  = req_tdata[TRACK_BITS-1:0];
      ctl.mark_en   = 1'b0;
      ctl.mark_idx  = best.idx;
      ctl.clear     = 1'b0;
      ctl.count     = count_ff;
      ctl.mode      = mode_ff;
      ctl.head      = head_ff;
      ctl.start     = start_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (count_ff < CNT_BITS'(MAX_REQUESTS)) begin
                  ctl.wr_en = 1'b1;
                  count_in  = count_ff + CNT_BITS'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  sum_in        = '0;
                  served_cnt_in = '0;
                  state_in      = ST_LAUNCH;
               end
            end
         end
         ST_LAUNCH: begin
            start_search = 1'b1;
            state_in     = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (best.live) begin
               ctl.mark_en   = 1'b1;
               head_in       = best.track;
               sum_in        = sum_next;
               served_cnt_in = served_cnt_ff + CNT_BITS'(1);
               rsp_track_in  = best.track;
               rsp_seek_in   = seek;
               rsp_total_in  = sum_next;
               rsp_last_in   = (served_cnt_ff + CNT_BITS'(1)) == count_ff;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (rsp_last_ff) begin
                  ctl.clear  = 1'b1;
                  count_in   = '0;
                  dropped_in = 1'b0;
                  head_in    = start_ff;
                  state_in   = ST_IDLE;
               end else begin
                  start_search = 1'b1;
                  state_in     = ST_SEARCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we && csr_addr == CSR_START) begin
         head_in = csr_wdata[TRACK_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_FCFS;
         start_ff      <= TRACK_BITS'(START_RESET);
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         head_ff       <= TRACK_BITS'(START_RESET);
         sum_ff        <= '0;
         served_cnt_ff <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         head_ff       <= head_in;
         sum_ff        <= sum_in;
         served_cnt_ff <= served_cnt_in;
         if (csr_we && csr_addr == CSR_MODE) begin
            mode_ff <= csr_wdata[1:0];
         end
         if (csr_we && csr_addr == CSR_START) begin
            start_ff <= csr_wdata[TRACK_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_track_ff <= rsp_track_in;
      rsp_seek_ff  <= rsp_seek_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, COUNT_FIELD_BITS'(count_ff), rsp_total_ff,
                       rsp_seek_ff, rsp_track_ff};
   assign rsp_tuser = dropped_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

@@ hdl/dsr_checker.sv @@
module dsr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tlast,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [dsr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                               rsp_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready
);
   import dsr_pkg::*;

   localparam int CNT_LSB = 2 * TRACK_BITS + SUM_BITS;

   // The block never loads while it is serving a batch.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and result channels active together");

   a_close_batch: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("block kept loading after the batch was closed");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("block did not return to loading after the final result");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[CNT_LSB +: COUNT_FIELD_BITS] != '0))
      else $error("result transaction reports an empty batch");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result transaction changed");

endmodule

bind disk_request_scheduler dsr_checker u_dsr_checker (.*);

@@ verif/disk_schedule_checker.sv @@
`timescale 1ns / 100ps

module disk_schedule_checker
   import dsr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tlast,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     rsp_tuser,
   input  logic                     rsp_tlast,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       mismatches,
   output int                       outstanding
);

   localparam int SEEK_LO  = TRACK_BITS;
   localparam int TOTAL_LO = 2 * TRACK_BITS;
   localparam int COUNT_LO = TOTAL_LO + SUM_BITS;

   typedef struct {
      logic [TRACK_BITS-1:0]       track;
      logic [TRACK_BITS-1:0]       seek;
      logic [SUM_BITS-1:0]         total;
      logic [COUNT_FIELD_BITS-1:0] count;
      logic                        overflow;
      logic                        last;
   } service_slot_type;

   service_slot_type      planned_service[$];
   logic [TRACK_BITS-1:0] track_store [MAX_REQUESTS];
   logic [1:0]            sched_mode;
   logic [TRACK_BITS-1:0] start_track;
   int                    batch_len;
   logic                  dropped;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic logic [TRACK_BITS-1:0] track_gap(input logic [TRACK_BITS-1:0] a,
                                                        input logic [TRACK_BITS-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Works out the service order of the stored batch, then the head moves along it.
   task automatic plan_service();
      logic [TRACK_BITS-1:0]   order  [MAX_REQUESTS];
      logic [TRACK_BITS-1:0]   sorted [MAX_REQUESTS];
      logic [MAX_REQUESTS-1:0] taken;
      logic [TRACK_BITS-1:0]   head;
      logic [TRACK_BITS-1:0]   seek;
      logic [TRACK_BITS-1:0]   key;
      int                      best;
      int                      split;
      int                      i;
      int                      j;
      int                      pos;
      int                      sum;
      service_slot_type        slot;
      taken = '0;
      head  = start_track;
      case (sched_mode)
         MODE_SSTF: begin
            for (pos = 0; pos < batch_len; pos++) begin
               best = -1;
               for (i = 0; i < batch_len; i++) begin
                  if (!taken[i] && (best < 0 || track_gap(head, track_store[i]) <
                                    track_gap(head, track_store[best]))) begin
                     best = i;
                  end
               end
               taken[best] = 1'b1;
               order[pos]  = track_store[best];
               head        = track_store[best];
            end
         end
         MODE_SCAN: begin
            for (i = 0; i < batch_len; i++) begin
               key = track_store[i];
               j   = i;
               while (j > 0 && sorted[j-1] > key) begin
                  sorted[j] = sorted[j-1];
                  j--;
               end
               sorted[j] = key;
            end
            split = 0;
            while (split < batch_len && sorted[split] <= start_track) begin
               split++;
            end
            pos = 0;
            for (i = split; i < batch_len; i++) begin
               order[pos] = sorted[i];
               pos++;
            end
            for (i = split - 1; i >= 0; i--) begin
               order[pos] = sorted[i];
               pos++;
            end
         end
         default: begin
            for (i = 0; i < batch_len; i++) begin
               order[i] = track_store[i];
            end
         end
      endcase
      head = start_track;
      sum  = 0;
      for (pos = 0; pos < batch_len; pos++) begin
         seek = track_gap(head, order[pos]);
         sum  = sum + int'(seek);
         if (sum > SUM_MAX) begin
            sum = SUM_MAX;
         end
         slot.track    = order[pos];
         slot.seek     = seek;
         slot.total    = SUM_BITS'(sum);
         slot.count    = COUNT_FIELD_BITS'(batch_len);
         slot.overflow = dropped;
         slot.last     = (pos == batch_len - 1);
         planned_service.push_back(slot);
         head = order[pos];
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      service_slot_type      want;
      logic [TRACK_BITS-1:0] trk;
      if (reset) begin
         sched_mode  = MODE_FCFS;
         start_track = TRACK_BITS'(START_RESET);
         batch_len   = 0;
         dropped     = 1'b0;
         planned_service.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MODE: begin
                  sched_mode = csr_wdata[1:0];
               end
               CSR_START: begin
                  start_track = csr_wdata[TRACK_BITS-1:0];
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (planned_service.size() == 0) begin
               $error("served_track: expected none, actual %0d", rsp_tdata[TRACK_BITS-1:0]);
               mismatches++;
            end else begin
               want = planned_service.pop_front();
               check_field("served_track", int'(want.track),
                           int'(rsp_tdata[SEEK_LO-1:0]));
               check_field("seek_distance", int'(want.seek),
                           int'(rsp_tdata[TOTAL_LO-1:SEEK_LO]));
               check_field("total_distance", int'(want.total),
                           int'(rsp_tdata[COUNT_LO-1:TOTAL_LO]));
               check_field("request_count", int'(want.count),
                           int'(rsp_tdata[COUNT_LO+COUNT_FIELD_BITS-1:COUNT_LO]));
               check_field("overflow", int'(want.overflow), int'(rsp_tuser));
               check_field("last_served", int'(want.last), int'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            trk = req_tdata[TRACK_BITS-1:0];
            if (batch_len < MAX_REQUESTS) begin
               track_store[batch_len] = trk;
               batch_len++;
            end else begin
               dropped = 1'b1;
            end
            if (req_tlast) begin
               plan_service();
               batch_len = 0;
               dropped   = 1'b0;
            end
         end
      end
      outstanding = planned_service.size();
   end

endmodule

@@ verif/tb_disk_request_scheduler.sv @@
`timescale 1ns / 100ps

module tb_disk_request_scheduler;
   import dsr_pkg::*;

   localparam int         RANDOM_ITEMS  = 220;
   localparam int         CALM_FROM     = 176;
   localparam int         CYCLE_LIMIT   = 500000;
   localparam int         SETTLE_CYCLES = MAX_REQUESTS + 4;
   localparam logic [1:0] MODE_SPARE    = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tlast;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     rsp_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic                     csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   int                       mismatches;
   int                       outstanding;
   int                       cycles = 0;
   bit                       calm = 1'b0;
   logic [TRACK_BITS-1:0]    cur_start = TRACK_BITS'(START_RESET);

   always #5 clock = ~clock;

   disk_request_scheduler DUT (.*);

   disk_schedule_checker checker_inst (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int run;
      forever begin
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         if (!calm) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   function automatic logic [TRACK_BITS-1:0] pick_track(input logic [TRACK_BITS-1:0] anchor);
      logic [TRACK_BITS-1:0] trk;
      case ($urandom_range(0, 7))
         0: begin
            trk = '0;
         end
         1: begin
            trk = '1;
         end
         2, 3: begin
            trk = anchor + TRACK_BITS'($urandom_range(0, 6)) - TRACK_BITS'(3);
         end
         default: begin
            trk = TRACK_BITS'($urandom_range(0, 1023));
         end
      endcase
      return trk;
   endfunction

   task automatic push_request(input logic [TRACK_BITS-1:0] trk, input logic fin);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(trk);
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
   endtask

   // Registers only change once the current batch has been fully served.
   task automatic write_csr(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int                       sent;
      int                       len;
      int                       k;
      logic [CSR_DATA_BITS-1:0] value;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_MODE;
      csr_wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_request(10'd0, 1'b0);
      push_request(10'd1023, 1'b0);
      push_request(10'd90, 1'b1);

      // Nearest first with a tie between 400 and 600 after reaching 500.
      write_csr(CSR_MODE, CSR_DATA_BITS'(MODE_SSTF));
      write_csr(CSR_START, 10'd500);
      cur_start = 10'd500;
      push_request(10'd600, 1'b0);
      push_request(10'd400, 1'b0);
      push_request(10'd500, 1'b1);

      // A request equal to the start track belongs to the downward sweep.
      write_csr(CSR_MODE, CSR_DATA_BITS'(MODE_SCAN));
      write_csr(CSR_START, 10'd1023);
      cur_start = 10'd1023;
      push_request(10'd0, 1'b0);
      push_request(10'd1023, 1'b0);
      push_request(10'd512, 1'b1);

      write_csr(CSR_MODE, CSR_DATA_BITS'(MODE_SPARE));
      push_request(10'd777, 1'b1);

      // Overfull batch whose closing request is itself dropped.
      write_csr(CSR_MODE, CSR_DATA_BITS'(MODE_SCAN));
      write_csr(CSR_START, '0);
      cur_start = '0;
      for (k = 0; k <= MAX_REQUESTS; k++) begin
         push_request((k == 0) ? '0 : pick_track(cur_start), k == MAX_REQUESTS);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            value      = CSR_DATA_BITS'($urandom_range(0, 1023));
            value[1:0] = 2'($urandom_range(0, 3));
            write_csr(CSR_MODE, value);
         end
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  value = '0;
               end
               1: begin
                  value = '1;
               end
               default: begin
                  value = CSR_DATA_BITS'($urandom_range(0, 1023));
               end
            endcase
            write_csr(CSR_START, value);
            cur_start = value[TRACK_BITS-1:0];
         end
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4)
                                          : $urandom_range(1, MAX_REQUESTS);
         for (k = 0; k < len; k++) begin
            push_request(pick_track(cur_start), k == len - 1);
            sent++;
            calm = (sent >= CALM_FROM);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2 * MAX_REQUESTS + 8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
